>>> rtl/resonant_sine_bank_macros.svh
// Assertion macros for the resonator bank checker.
`ifndef RESONANT_SINE_BANK_MACROS_SVH
`define RESONANT_SINE_BANK_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RSB_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define RSB_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/rsb_pkg.sv
// Shared types, constants and sine table function for the resonator bank.
package rsb_pkg;
  localparam int unsigned LevelW = 21;
  localparam logic [15:0] GainReset = 16'sd4096;

  typedef enum logic [1:0] {
    REG_NUM_PARTIALS = 2'd0,
    REG_OUTPUT_SCALE = 2'd1,
    REG_LEVEL_LIMIT  = 2'd2
  } reg_idx_e;

  // One partial's state as held in the state memory.
  typedef struct packed {
    logic [31:0]       phase;
    logic [LevelW-1:0] level;
  } part_state_t;

  // One partial's coefficients.
  typedef struct packed {
    logic [23:0] ratio;
    logic [15:0] gain;
    logic [23:0] decay;
  } part_coef_t;

  // Quarter-wave sine, Q1.15, evaluated at elaboration (constant tables).
  // The quarter wave holds 2^qbits entries.
  function automatic logic [15:0] quarter_sine(longint unsigned q, int unsigned qbits);
    longint unsigned x, x2, t, s, r;
    x  = (q * 64'd1686629713) >> qbits;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] table_entry(int unsigned k, int unsigned tbits);
    longint unsigned n, quarter, kk, quad, rr;
    logic [15:0] v;
    n       = 64'd1 << tbits;
    quarter = n >> 2;
    kk      = k & (n - 1);
    quad    = kk >> (tbits - 2);
    rr      = kk & (quarter - 1);
    v = quad[0] ? quarter_sine(quarter - rr, tbits - 2) : quarter_sine(rr, tbits - 2);
    return quad[1] ? -v : v;
  endfunction
endpackage

>>> rtl/rsb_sine.sv
// Sine table with linear interpolation, two registered stages.
module rsb_sine import rsb_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [15:0] sine_o
);
  localparam int unsigned N  = 1 << SINE_TABLE_BITS;
  localparam int unsigned FR = 32 - SINE_TABLE_BITS;

  logic signed [15:0] sine_tab [N];
  for (genvar k = 0; k < N; k++) begin : g_tab
    assign sine_tab[k] = table_entry(k, SINE_TABLE_BITS);
  end

  logic [SINE_TABLE_BITS-1:0] idx, idx1;
  logic signed [15:0] s0_q, s1_q;
  logic [FR-1:0] f_q;
  logic signed [16:0] diff;
  logic signed [FR+17:0] prod;

  assign idx  = phase_i[31:FR];
  assign idx1 = idx + 1'b1;

  always_ff @(posedge clk_i) begin
    s0_q <= sine_tab[idx];
    s1_q <= sine_tab[idx1];
    f_q  <= phase_i[FR-1:0];
  end

  assign diff = 17'(s1_q) - 17'(s0_q);
  assign prod = (FR+18)'(diff) * $signed({1'b0, f_q});

  always_ff @(posedge clk_i) begin
    sine_o <= 16'(s0_q + 16'(prod >>> FR));
  end
endmodule

>>> rtl/rsb_datapath.sv
// Per-partial update pipeline: excitation, clamp, phase advance, decay, accumulate.
module rsb_datapath import rsb_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               start_i,
  input  logic               valid_i,
  input  part_state_t        st_i,
  input  part_coef_t         cf_i,
  input  logic signed [15:0] exc_i,
  input  logic [31:0]        step_i,
  input  logic [18:0]        limit_i,
  output logic               wb_valid_o,
  output part_state_t        wb_o,
  output logic signed [63:0] acc_o
);
  // stage 1: level update and step*ratio
  logic signed [31:0] eg;
  logic signed [22:0] lvl_sum;
  logic signed [22:0] lim_p, lim_n;
  logic signed [LevelW-1:0] lvl_c;
  assign eg      = exc_i * $signed(cf_i.gain);
  assign lvl_sum = 23'($signed(st_i.level)) + 23'(eg >>> 11);
  assign lim_p   = $signed({4'd0, limit_i});
  assign lim_n   = -lim_p;
  always_comb begin
    if (lvl_sum > lim_p) lvl_c = LevelW'(lim_p);
    else if (lvl_sum < lim_n) lvl_c = LevelW'(lim_n);
    else lvl_c = LevelW'(lvl_sum);
  end

  logic v1_q, v2_q, v3_q, s1_q, s2_q, s3_q;
  logic signed [LevelW-1:0] lvl1_q, lvl2_q;
  logic [31:0] ph1_q, ph2_q;
  logic [55:0] sr1_q;
  logic [23:0] dec1_q;
  logic signed [44:0] ld2_q;
  logic signed [15:0] sine;

  always_ff @(posedge clk_i) begin
    v1_q <= valid_i; s1_q <= start_i;
    lvl1_q <= lvl_c; ph1_q <= st_i.phase;
    sr1_q <= step_i * cf_i.ratio; dec1_q <= cf_i.decay;
    v2_q <= v1_q; s2_q <= s1_q;
    lvl2_q <= lvl1_q;
    ph2_q <= ph1_q + sr1_q[47:16];
    ld2_q <= lvl1_q * $signed({1'b0, dec1_q});
    v3_q <= v2_q; s3_q <= s2_q;
  end

  rsb_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk_i(clk_i), .phase_i(st_i.phase), .sine_o(sine)
  );

  // write back after stage 2; sine is aligned with stage 2 level
  assign wb_valid_o  = v2_q;
  assign wb_o.phase  = ph2_q;
  assign wb_o.level  = LevelW'(ld2_q >>> 24);

  logic signed [LevelW-1:0] lvl3_q;
  logic signed [15:0] sine3_q;
  always_ff @(posedge clk_i) begin
    lvl3_q <= lvl2_q; sine3_q <= sine;
  end
  logic signed [63:0] acc_q;
  always_ff @(posedge clk_i) begin
    if (v3_q) acc_q <= (s3_q ? 64'sd0 : acc_q) + 64'(sine3_q) * 64'(lvl3_q);
    else if (s3_q) acc_q <= '0;
  end
  assign acc_o = acc_q;
endmodule

>>> rtl/resonant_sine_bank.sv
// Top level of the decaying sine resonator bank.
// A sample passes the states in order: RUN reads the active partials one after
// another from the state memory and then leaves the read loop, DRAIN lets the last
// partial pass the update pipeline and be written back, and SCALE scales the sum.
// The block takes no new item while a sample is in progress. A coefficient write
// gives no result; a zero step or no active partials give a zero result in the
// cycle after the transfer. The result waits in an output register and holds the
// input off until it is taken. No clearing pass is needed: entries read as their
// reset values until first written, tracked by per-entry valid bits.
module resonant_sine_bank import rsb_pkg::*; #(
  parameter int unsigned MAX_PARTIALS    = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic signed [15:0] excitation_i,
  input  logic [31:0] base_step_i,
  input  logic [5:0]  partial_index_i,
  input  logic [23:0] ratio_i,
  input  logic signed [15:0] gain_i,
  input  logic [23:0] decay_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] sample_out_o
);
  localparam int unsigned AW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, SCALE} state_e;

  logic [6:0]  num_q;
  logic [15:0] scale_q;
  logic [18:0] limit_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0; scale_q <= 16'hFFFF; limit_q <= 19'd327680;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_NUM_PARTIALS: num_q   <= pwdata[6:0];
        REG_OUTPUT_SCALE: scale_q <= pwdata[15:0];
        REG_LEVEL_LIMIT:  limit_q <= pwdata[18:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_NUM_PARTIALS: prdata = {25'd0, num_q};
      REG_OUTPUT_SCALE: prdata = {16'd0, scale_q};
      REG_LEVEL_LIMIT:  prdata = {13'd0, limit_q};
      default:          prdata = '0;
    endcase
  end

  // memories
  part_state_t st_mem [MAX_PARTIALS];
  part_coef_t  cf_mem [MAX_PARTIALS];
  logic [MAX_PARTIALS-1:0] st_vld_q, cf_vld_q;
  part_state_t st_rd_q, st_rd;
  part_coef_t  cf_rd_q, cf_rd;
  logic st_rv_q, cf_rv_q;

  state_e state_q;
  logic [AW:0] rd_cnt_q, n_act;
  logic [AW-1:0] wb_addr_q;
  logic signed [15:0] exc_q;
  logic [31:0] step_q;
  logic rd_en_q, start_q;
  logic [3:0] drain_q;
  logic out_v_q;
  logic signed [15:0] out_q;
  logic accept, do_rd;

  assign n_act = (32'(num_q) > MAX_PARTIALS) ? (AW+1)'(MAX_PARTIALS) : (AW+1)'(num_q);
  assign in_stall_o = (state_q != IDLE) || out_v_q;
  assign accept = in_valid_i && !in_stall_o;
  assign do_rd = (state_q == RUN) && (rd_cnt_q < n_act);

  logic wb_v;
  part_state_t wb;
  logic signed [63:0] acc;

  always_ff @(posedge clk_i) begin
    st_rd_q <= st_mem[rd_cnt_q[AW-1:0]];
    cf_rd_q <= cf_mem[rd_cnt_q[AW-1:0]];
    if (wb_v) st_mem[wb_addr_q] <= wb;
    if (accept && func_i && 32'(partial_index_i) < MAX_PARTIALS)
      cf_mem[AW'(partial_index_i)] <= '{ratio: ratio_i, gain: gain_i, decay: decay_i};
  end

  always_ff @(posedge clk_i) begin
    st_rv_q <= st_vld_q[rd_cnt_q[AW-1:0]];
    cf_rv_q <= cf_vld_q[rd_cnt_q[AW-1:0]];
  end
  assign st_rd = st_rv_q ? st_rd_q : '0;
  assign cf_rd = cf_rv_q ? cf_rd_q : '{ratio: '0, gain: GainReset, decay: '0};

  logic signed [79:0] yprod;
  logic signed [47:0] ysh;
  logic signed [15:0] ysat;
  assign yprod = acc * $signed({1'b0, scale_q});
  assign ysh = 48'(yprod >>> 32);
  assign ysat = (ysh > 48'sd32767) ? 16'sh7FFF : (ysh < -48'sd32768) ? 16'sh8000 : 16'(ysh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE; rd_cnt_q <= '0; wb_addr_q <= '0; rd_en_q <= 1'b0;
      start_q <= 1'b0; drain_q <= '0; out_v_q <= 1'b0; out_q <= '0;
      st_vld_q <= '0; cf_vld_q <= '0; exc_q <= '0; step_q <= '0;
    end else begin
      rd_en_q <= do_rd;
      start_q <= do_rd && (rd_cnt_q == '0);
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (wb_v) begin
        st_vld_q[wb_addr_q] <= 1'b1;
        wb_addr_q <= wb_addr_q + 1'b1;
      end
      case (state_q)
        IDLE: if (accept) begin
          if (func_i) begin
            if (32'(partial_index_i) < MAX_PARTIALS) cf_vld_q[AW'(partial_index_i)] <= 1'b1;
          end else if (base_step_i == '0 || n_act == '0) begin
            out_v_q <= 1'b1; out_q <= '0;
          end else begin
            exc_q <= excitation_i; step_q <= base_step_i;
            rd_cnt_q <= '0; wb_addr_q <= '0; state_q <= RUN;
          end
        end
        RUN: begin
          if (do_rd) rd_cnt_q <= rd_cnt_q + 1'b1;
          else begin state_q <= DRAIN; drain_q <= 4'd6; end
        end
        DRAIN: begin
          if (drain_q == '0) state_q <= SCALE;
          else drain_q <= drain_q - 1'b1;
        end
        SCALE: begin
          out_v_q <= 1'b1; out_q <= ysat; state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  rsb_datapath #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
    .clk_i(clk_i), .start_i(start_q), .valid_i(rd_en_q), .st_i(st_rd), .cf_i(cf_rd),
    .exc_i(exc_q), .step_i(step_q), .limit_i(limit_q),
    .wb_valid_o(wb_v), .wb_o(wb), .acc_o(acc)
  );

  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_q;
endmodule

>>> rtl/rsb_checker.sv
// Port-level checker for the resonator bank, bound to the top level.
`include "resonant_sine_bank_macros.svh"
module rsb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic func_i,
  input logic [31:0] base_step_i,
  input logic signed [15:0] sample_out_o
);
  `RSB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sample_out_o))
  `RSB_ASSERT_IMP(a_stall_pending, clk_i, rst_ni, out_valid_o, in_stall_o)
  `RSB_ASSERT_NEXT(a_write_no_out, clk_i, rst_ni, in_valid_i && !in_stall_o && func_i, !out_valid_o)
  `RSB_ASSERT_NEXT(a_zero_step, clk_i, rst_ni, in_valid_i && !in_stall_o && !func_i && base_step_i == 32'd0, out_valid_o && sample_out_o == 16'sd0)
endmodule

bind resonant_sine_bank rsb_checker u_rsb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .func_i(func_i),
  .base_step_i(base_step_i), .sample_out_o(sample_out_o)
);
